// ===== sv/lsfs_pkg.sv =====
package lsfs_pkg;

   localparam int COLOR_W   = 24;
   localparam int LENGTH_W  = 11;
   localparam int LATCH_W   = 16;
   localparam int INDEX_W   = 10;
   localparam int OP_W      = 2;
   localparam int BITPOS_W  = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   // wide enough for any strip length and for store depths below 2**17
   localparam int SWEEP_W   = 17;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
   localparam logic [OP_W-1:0] OP_SHOW  = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_STRIP_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LATCH_TICKS  = 1'd1;

   localparam logic [LENGTH_W-1:0] STRIP_LENGTH_RESET = 11'd0;
   localparam logic [LATCH_W-1:0]  LATCH_TICKS_RESET  = 16'd500;
   localparam logic [BITPOS_W-1:0] BITS_PER_PIXEL     = 5'd24;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_READY,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

endpackage

// ===== sv/led_strip_frame_serializer.sv =====
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+---------------------------------------
// request   | start, busy, req_item          | taken at edge with start & !busy
// response  | rsp_strobe, rsp_item           | one-cycle strobe, cannot be stalled
// csr       | csr_we, csr_index, csr_wdata   | written at edge with csr_we high
//
// Each transaction gives one response, strobed the cycle after it is taken.
// A tick that keeps its pixel, or a refused command, leaves busy low. A write, a
// tick that moves to the next pixel, or a show that moves the current pixel back
// to zero is followed by busy while the registered memory read catches up.
// A nonzero fill holds busy while it writes all eff_len entries; an empty fill does not.
// After reset the clearing pass holds busy while it zeroes all MAX_PIXELS entries;
// csr writes are taken throughout. The receiver cannot stall responses.
module led_strip_frame_serializer #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  lsfs_pkg::req_type                    req_item,
   output logic                                 rsp_strobe,
   output lsfs_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_we,
   input  logic [lsfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsfs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CP_W = lsfs_pkg::LENGTH_W;
   localparam logic [lsfs_pkg::SWEEP_W-1:0] DEPTH = lsfs_pkg::SWEEP_W'(MAX_PIXELS);

   // configuration
   logic [lsfs_pkg::LENGTH_W-1:0] strip_len_ff;
   logic [lsfs_pkg::LATCH_W-1:0]  latch_ticks_ff;

   // sequencer and frame state
   lsfs_pkg::state_type           state_ff, state_in;
   logic [lsfs_pkg::SWEEP_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic [lsfs_pkg::SWEEP_W-1:0]  sweep_end_ff, sweep_end_in;
   logic [lsfs_pkg::COLOR_W-1:0]  fill_color_ff, fill_color_in;
   logic                          frame_active_ff, frame_active_in;
   logic [lsfs_pkg::LATCH_W-1:0]  latch_count_ff, latch_count_in;
   logic [CP_W-1:0]               cur_pixel_ff, cur_pixel_in;
   logic [lsfs_pkg::BITPOS_W-1:0] bit_pos_ff, bit_pos_in;
   logic                          bit_phase_ff, bit_phase_in;
   logic [lsfs_pkg::COLOR_W-1:0]  shift_word_ff, shift_word_in;
   logic                          clock_out_ff, clock_out_in;
   logic                          data_out_ff, data_out_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   lsfs_pkg::rsp_type             rsp_item_ff, rsp_item_in;

   // pixel memory
   logic [lsfs_pkg::COLOR_W-1:0]  pixel_mem [MAX_PIXELS];
   logic [lsfs_pkg::COLOR_W-1:0]  mem_rd_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_wa;
   logic [AW-1:0]                 mem_ra;
   logic [lsfs_pkg::COLOR_W-1:0]  mem_wd;

   logic                          accept;
   logic [CP_W-1:0]               eff_len;
   logic                          sweep_last;
   logic                          end_check;
   logic                          ok;
   logic [lsfs_pkg::COLOR_W-1:0]  word;
   logic [lsfs_pkg::BITPOS_W-1:0] bit_pos_next;
   logic [AW+CP_W-1:0]            cp_ext;
   logic [AW+lsfs_pkg::INDEX_W-1:0] idx_ext;

   // strip length is clamped to the store depth
   always_comb begin
      if ({6'd0, strip_len_ff} > DEPTH) begin
         eff_len = DEPTH[CP_W-1:0];
      end else begin
         eff_len = strip_len_ff;
      end
   end

   // read port always follows the current pixel; rd_valid says the word is fresh
   assign cp_ext  = {{AW{1'b0}}, cur_pixel_ff};
   assign idx_ext = {{AW{1'b0}}, req_item.pixel_index};
   assign mem_ra  = cp_ext[AW-1:0];

   assign busy       = (state_ff != lsfs_pkg::ST_READY) || !rd_valid_ff;
   assign accept     = start && !busy;
   assign sweep_last = lsfs_pkg::SWEEP_W'(sweep_cnt_ff + 1'b1) == sweep_end_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      state_in        = state_ff;
      sweep_cnt_in    = sweep_cnt_ff;
      sweep_end_in    = sweep_end_ff;
      fill_color_in   = fill_color_ff;
      frame_active_in = frame_active_ff;
      latch_count_in  = latch_count_ff;
      cur_pixel_in    = cur_pixel_ff;
      bit_pos_in      = bit_pos_ff;
      bit_phase_in    = bit_phase_ff;
      shift_word_in   = shift_word_ff;
      clock_out_in    = clock_out_ff;
      data_out_in     = data_out_ff;
      rsp_strobe_in   = 1'b0;
      mem_we          = 1'b0;
      mem_wa          = sweep_cnt_ff[AW-1:0];
      mem_wd          = fill_color_ff;
      end_check       = 1'b0;
      ok              = 1'b1;
      word            = shift_word_ff;
      bit_pos_next    = lsfs_pkg::BITPOS_W'(bit_pos_ff + 1'b1);

      case (state_ff)
         lsfs_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            sweep_cnt_in = lsfs_pkg::SWEEP_W'(sweep_cnt_ff + 1'b1);
            if (sweep_last) begin
               state_in = lsfs_pkg::ST_READY;
            end
         end
         lsfs_pkg::ST_FILL: begin
            mem_we = 1'b1;
            sweep_cnt_in = lsfs_pkg::SWEEP_W'(sweep_cnt_ff + 1'b1);
            if (sweep_last) begin
               state_in = lsfs_pkg::ST_READY;
            end
         end
         lsfs_pkg::ST_READY: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               if (req_item.op == lsfs_pkg::OP_TICK) begin
                  if (frame_active_ff) begin
                     end_check = 1'b1;
                     if (latch_count_ff < latch_ticks_ff) begin
                        latch_count_in = latch_count_ff + 1'b1;
                     end else if (cur_pixel_ff >= eff_len) begin
                        // nothing left to send, frame closes below
                     end else if (!bit_phase_ff) begin
                        // clock low, data set up; new pixel word at bit 0
                        if (bit_pos_ff == '0) begin
                           word = mem_rd_ff;
                        end
                        shift_word_in = word;
                        clock_out_in  = 1'b0;
                        data_out_in   = word[lsfs_pkg::COLOR_W-1];
                        bit_phase_in  = 1'b1;
                     end else begin
                        // clock high, strip latches the bit
                        clock_out_in  = 1'b1;
                        shift_word_in = {shift_word_ff[lsfs_pkg::COLOR_W-2:0], 1'b0};
                        bit_phase_in  = 1'b0;
                        if (bit_pos_next == lsfs_pkg::BITS_PER_PIXEL) begin
                           bit_pos_in   = '0;
                           cur_pixel_in = CP_W'(cur_pixel_ff + 1'b1);
                        end else begin
                           bit_pos_in = bit_pos_next;
                        end
                     end
                  end
               end else if (frame_active_ff) begin
                  ok = 1'b0;
               end else if (req_item.op == lsfs_pkg::OP_WRITE) begin
                  if ({1'b0, req_item.pixel_index} < eff_len) begin
                     mem_we = 1'b1;
                     mem_wa = idx_ext[AW-1:0];
                     mem_wd = req_item.pixel_color;
                  end else begin
                     ok = 1'b0;
                  end
               end else if (req_item.op == lsfs_pkg::OP_FILL) begin
                  if (eff_len != '0) begin
                     state_in      = lsfs_pkg::ST_FILL;
                     sweep_cnt_in  = '0;
                     sweep_end_in  = {6'd0, eff_len};
                     fill_color_in = req_item.pixel_color;
                  end
               end else begin
                  frame_active_in = 1'b1;
                  latch_count_in  = '0;
                  cur_pixel_in    = '0;
                  bit_pos_in      = '0;
                  bit_phase_in    = 1'b0;
                  shift_word_in   = '0;
                  clock_out_in    = 1'b0;
                  end_check       = 1'b1;
               end
            end
         end
         default: begin
            state_in = lsfs_pkg::ST_READY;
         end
      endcase

      // frame end: latch done and all pixels sent
      if (end_check && frame_active_in && (latch_count_in >= latch_ticks_ff) &&
          (cur_pixel_in >= eff_len)) begin
         frame_active_in = 1'b0;
         clock_out_in    = 1'b1;
         bit_phase_in    = 1'b0;
         bit_pos_in      = '0;
      end

      rd_valid_in = !mem_we && (cur_pixel_in == cur_pixel_ff);
      rsp_item_in = '{clock_level: clock_out_in, data_level: data_out_in,
                      busy_res: frame_active_in, accepted: ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lsfs_pkg::ST_CLEAR;
         sweep_cnt_ff    <= '0;
         sweep_end_ff    <= DEPTH;
         frame_active_ff <= 1'b0;
         latch_count_ff  <= '0;
         cur_pixel_ff    <= '0;
         bit_pos_ff      <= '0;
         bit_phase_ff    <= 1'b0;
         shift_word_ff   <= '0;
         clock_out_ff    <= 1'b1;
         data_out_ff     <= 1'b0;
         rd_valid_ff     <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_cnt_ff    <= sweep_cnt_in;
         sweep_end_ff    <= sweep_end_in;
         frame_active_ff <= frame_active_in;
         latch_count_ff  <= latch_count_in;
         cur_pixel_ff    <= cur_pixel_in;
         bit_pos_ff      <= bit_pos_in;
         bit_phase_ff    <= bit_phase_in;
         shift_word_ff   <= shift_word_in;
         clock_out_ff    <= clock_out_in;
         data_out_ff     <= data_out_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fill_color_ff <= fill_color_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff   <= lsfs_pkg::STRIP_LENGTH_RESET;
         latch_ticks_ff <= lsfs_pkg::LATCH_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lsfs_pkg::REG_STRIP_LENGTH: strip_len_ff   <= csr_wdata[lsfs_pkg::LENGTH_W-1:0];
            lsfs_pkg::REG_LATCH_TICKS:  latch_ticks_ff <= csr_wdata[lsfs_pkg::LATCH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pixel memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= pixel_mem[mem_ra];
   end

`ifndef SYNTHESIS
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response strobe missing after accepted transaction");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response strobe without accepted transaction");

   a_idle_clock_high: assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> clock_out_ff)
      else $error("strip clock low outside a frame");

   a_no_fill_in_frame: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> (state_ff == lsfs_pkg::ST_READY))
      else $error("memory sweep during a frame");

   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff < lsfs_pkg::BITS_PER_PIXEL)
      else $error("bit position out of range");
`endif

endmodule

// ===== tb/led_strip_frame_serializer_test.sv =====
module led_strip_frame_serializer_test;

   // Generous ceiling on the run.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int NUM_PIXELS   = 1024;

   // Tracks the strip lines the block should drive. Every accepted transaction
   // is run through a copy of the pixel store and frame sequencer, and the
   // predicted line levels wait in a queue for the matching response.
   class strip_line_tracker;
      logic [lsfs_pkg::COLOR_W-1:0]  colors [NUM_PIXELS];
      logic [lsfs_pkg::LENGTH_W-1:0] strip_len;
      logic [lsfs_pkg::LATCH_W-1:0]  latch_len;
      logic                          active;
      logic [lsfs_pkg::LATCH_W-1:0]  latch_cnt;
      logic [lsfs_pkg::LENGTH_W-1:0] pix;
      logic [lsfs_pkg::BITPOS_W-1:0] bitpos;
      logic                          phase;
      logic [lsfs_pkg::COLOR_W-1:0]  shreg;
      logic                          clk_o;
      logic                          dat_o;
      lsfs_pkg::rsp_type             expected_levels [$];
      int                            errors;

      function new();
         foreach (colors[i]) colors[i] = '0;
         strip_len = lsfs_pkg::STRIP_LENGTH_RESET;
         latch_len = lsfs_pkg::LATCH_TICKS_RESET;
         active    = 1'b0;
         latch_cnt = '0;
         pix       = '0;
         bitpos    = '0;
         phase     = 1'b0;
         shreg     = '0;
         clk_o     = 1'b1;
         dat_o     = 1'b0;
         errors    = 0;
      endfunction

      function logic [lsfs_pkg::LENGTH_W-1:0] eff_len();
         return (strip_len > 11'd1024) ? 11'd1024 : strip_len;
      endfunction

      function int queued();
         return expected_levels.size();
      endfunction

      function void set_reg(logic [lsfs_pkg::CSR_IDX_W-1:0] idx,
                            logic [lsfs_pkg::CSR_DATA_W-1:0] data);
         if (idx == lsfs_pkg::REG_STRIP_LENGTH)
            strip_len = data[lsfs_pkg::LENGTH_W-1:0];
         else if (idx == lsfs_pkg::REG_LATCH_TICKS)
            latch_len = data;
      endfunction

      // frame is over once latch and all pixels are done; clock returns high
      function void close_frame();
         if (active && latch_cnt >= latch_len && pix >= eff_len()) begin
            active = 1'b0;
            clk_o  = 1'b1;
            phase  = 1'b0;
            bitpos = '0;
         end
      endfunction

      function void tick();
         if (!active) return;
         if (latch_cnt < latch_len) begin
            latch_cnt++;
            close_frame();
            return;
         end
         if (pix >= eff_len()) begin
            close_frame();
            return;
         end
         if (!phase) begin
            if (bitpos == '0) shreg = colors[pix[9:0]];
            clk_o = 1'b0;
            dat_o = shreg[lsfs_pkg::COLOR_W-1];
            phase = 1'b1;
         end else begin
            clk_o = 1'b1;
            shreg = shreg << 1;
            phase = 1'b0;
            bitpos++;
            if (bitpos >= lsfs_pkg::BITS_PER_PIXEL) begin
               bitpos = '0;
               pix++;
            end
            close_frame();
         end
      endfunction

      function void take_item(lsfs_pkg::req_type it);
         logic                          ok;
         logic [lsfs_pkg::LENGTH_W-1:0] len;
         lsfs_pkg::rsp_type             r;
         ok  = 1'b1;
         len = eff_len();
         if (it.op == lsfs_pkg::OP_TICK) begin
            tick();
         end else if (active) begin
            ok = 1'b0;
         end else if (it.op == lsfs_pkg::OP_WRITE) begin
            if ({1'b0, it.pixel_index} < len)
               colors[it.pixel_index] = it.pixel_color;
            else
               ok = 1'b0;
         end else if (it.op == lsfs_pkg::OP_FILL) begin
            for (int i = 0; i < int'(len); i++) colors[i[9:0]] = it.pixel_color;
         end else begin
            active    = 1'b1;
            latch_cnt = '0;
            pix       = '0;
            bitpos    = '0;
            phase     = 1'b0;
            shreg     = '0;
            clk_o     = 1'b0;
            close_frame();
         end
         r.clock_level = clk_o;
         r.data_level  = dat_o;
         r.busy_res    = active;
         r.accepted    = ok;
         expected_levels.push_back(r);
      endfunction

      function void match_levels(lsfs_pkg::rsp_type got);
         lsfs_pkg::rsp_type want;
         if (expected_levels.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         if (got.clock_level !== want.clock_level) begin
            $error("clock_level: expected %0b, got %0b", want.clock_level, got.clock_level);
            errors++;
         end
         if (got.data_level !== want.data_level) begin
            $error("data_level: expected %0b, got %0b", want.data_level, got.data_level);
            errors++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            errors++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   lsfs_pkg::req_type               req_item = '0;
   logic                            rsp_strobe;
   lsfs_pkg::rsp_type               rsp_item;
   logic                            csr_we = 1'b0;
   logic [lsfs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lsfs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   strip_line_tracker lines = new();
   int sent_items = 0;
   int burst_left = 0;

   led_strip_frame_serializer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor: every signal here is driven by nonblocking assignment, so at the
   // edge we see the values that the block itself sampled. Responses are
   // checked before the new transaction is noted; the queue keeps them apart.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) lines.match_levels(rsp_item);
         if (start && !busy) lines.take_item(req_item);
      end
   end

   // Offer one transaction and hold it until the block takes it. The sender
   // runs in bursts; between bursts start is often dropped, so gaps land
   // on every phase of the frame, including the busy time after a pixel.
   task automatic push_item(input logic [lsfs_pkg::OP_W-1:0] op,
                            input logic [lsfs_pkg::INDEX_W-1:0] idx,
                            input logic [lsfs_pkg::COLOR_W-1:0] color);
      lsfs_pkg::req_type it;
      int                gap;
      it.op          = op;
      it.pixel_index = idx;
      it.pixel_color = color;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // long bursts now and then give stretches with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_items++;
   endtask

   // Ticks with random don't-care payload; noisy runs mix in random commands,
   // which a running frame refuses.
   task automatic run_ticks(input int n, input bit noisy);
      repeat (n) begin
         if (noisy && $urandom_range(0, 7) == 0)
            push_item(lsfs_pkg::OP_W'($urandom_range(0, 3)), lsfs_pkg::INDEX_W'($urandom),
                      lsfs_pkg::COLOR_W'($urandom));
         else
            push_item(lsfs_pkg::OP_TICK, lsfs_pkg::INDEX_W'($urandom),
                      lsfs_pkg::COLOR_W'($urandom));
      end
   endtask

   // Quiesce: no responses outstanding and no fill or read cycle in flight.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (lines.queued() != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   // Called after settle or after another write_reg. The wait after csr_we drops
   // keeps it from being lowered and raised in one step by back-to-back writes.
   task automatic write_reg(input logic [lsfs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lsfs_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      lines.set_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One random frame cycle: configure, load pixels, show, clock it out.
   // Mostly short strips so frames run to completion; about one run in eight uses
   // full-width register values and is cut short by zeroing both registers.
   task automatic run_frame_sequence();
      int len;
      int lat;
      int n;
      bit wide;
      settle();
      wide = ($urandom_range(0, 7) == 0);
      if (wide) begin
         lat = 0;
         write_reg(lsfs_pkg::REG_STRIP_LENGTH, lsfs_pkg::CSR_DATA_W'($urandom));
         write_reg(lsfs_pkg::REG_LATCH_TICKS, lsfs_pkg::CSR_DATA_W'($urandom));
      end else begin
         lat = $urandom_range(0, 8);
         write_reg(lsfs_pkg::REG_STRIP_LENGTH, lsfs_pkg::CSR_DATA_W'($urandom_range(0, 4)));
         write_reg(lsfs_pkg::REG_LATCH_TICKS, lsfs_pkg::CSR_DATA_W'(lat));
      end
      len = int'(lines.eff_len());
      n = $urandom_range(0, 6);
      repeat (n) begin
         if (len == 0 || $urandom_range(0, 4) == 0)
            push_item(lsfs_pkg::OP_WRITE, lsfs_pkg::INDEX_W'($urandom),
                      lsfs_pkg::COLOR_W'($urandom));
         else
            push_item(lsfs_pkg::OP_WRITE, lsfs_pkg::INDEX_W'($urandom_range(0, len - 1)),
                      lsfs_pkg::COLOR_W'($urandom));
      end
      if ($urandom_range(0, 3) == 0)
         push_item(lsfs_pkg::OP_FILL, lsfs_pkg::INDEX_W'($urandom),
                   lsfs_pkg::COLOR_W'($urandom));
      if ($urandom_range(0, 9) != 0)
         push_item(lsfs_pkg::OP_SHOW, lsfs_pkg::INDEX_W'($urandom),
                   lsfs_pkg::COLOR_W'($urandom));
      if (wide) begin
         run_ticks($urandom_range(0, 80), 1'b1);
         settle();
         // shrinking both registers mid-frame ends the frame at the next tick
         write_reg(lsfs_pkg::REG_STRIP_LENGTH, '0);
         write_reg(lsfs_pkg::REG_LATCH_TICKS, '0);
         run_ticks(2, 1'b0);
      end else begin
         run_ticks(lat + 48 * len + $urandom_range(0, 4), 1'b1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // idle tick, then a write against the reset length of zero
      push_item(lsfs_pkg::OP_TICK, '0, '0);
      push_item(lsfs_pkg::OP_WRITE, '0, 24'hFFFFFF);
      settle();
      // length above the store depth is clamped; last entry reachable
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, 16'd2047);
      write_reg(lsfs_pkg::REG_LATCH_TICKS, '0);
      push_item(lsfs_pkg::OP_FILL, 10'h3ff, 24'hFFFFFF);
      push_item(lsfs_pkg::OP_WRITE, '0, '0);
      push_item(lsfs_pkg::OP_WRITE, 10'd1023, 24'h5A5A5A);
      settle();
      // index equal to length is out of range
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, 16'd1023);
      push_item(lsfs_pkg::OP_WRITE, 10'd1023, 24'h123456);
      settle();
      // short frame; commands during it are refused
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, 16'd2);
      write_reg(lsfs_pkg::REG_LATCH_TICKS, 16'd3);
      push_item(lsfs_pkg::OP_SHOW, '0, '0);
      push_item(lsfs_pkg::OP_WRITE, '0, 24'hA5A5A5);
      push_item(lsfs_pkg::OP_FILL, '0, 24'h0F0F0F);
      push_item(lsfs_pkg::OP_SHOW, '0, '0);
      run_ticks(3 + 96 + 2, 1'b0);
      settle();
      // empty frame finishes inside the show transaction
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, '0);
      write_reg(lsfs_pkg::REG_LATCH_TICKS, '0);
      push_item(lsfs_pkg::OP_SHOW, '0, '0);
      settle();
      // longest latch, shortened while the frame runs, then the length too
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, 16'd2047);
      write_reg(lsfs_pkg::REG_LATCH_TICKS, 16'hFFFF);
      push_item(lsfs_pkg::OP_SHOW, '0, '0);
      run_ticks(5, 1'b0);
      settle();
      write_reg(lsfs_pkg::REG_LATCH_TICKS, 16'd2);
      run_ticks(50, 1'b0);
      settle();
      write_reg(lsfs_pkg::REG_STRIP_LENGTH, 16'd1);
      run_ticks(4, 1'b0);

      // --- random ---
      while (sent_items < RANDOM_ITEMS) run_frame_sequence();

      settle();
      repeat (20) @(posedge clock);
      if (lines.errors == 0 && lines.queued() == 0)
         $display("led_strip_frame_serializer_test: done, clean");
      else
         $display("led_strip_frame_serializer_test: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("led_strip_frame_serializer_test: done, errors");
      $finish;
   end

endmodule
